### sv/nshf_pkg.sv
`default_nettype none

package nshf_pkg;

  // field widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned CHAN_W    = 20;
  localparam int unsigned SIGMA_W   = 16;
  localparam int unsigned FACTOR_W  = 8;
  localparam int unsigned DIVISOR_W = 16;
  localparam int unsigned HIT_W     = 32;

  // stream word widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 120;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_SIGMA   = 2'd0,
    REG_FACTOR  = 2'd1,
    REG_DIVISOR = 2'd2
  } reg_index_t;

  localparam logic [SIGMA_W-1:0]   SIGMA_RST   = 16'd1280;
  localparam logic [FACTOR_W-1:0]  FACTOR_RST  = 8'd1;
  localparam logic [DIVISOR_W-1:0] DIVISOR_RST = 16'd1;

  typedef struct packed {
    logic [SIGMA_W-1:0]   sigma;
    logic [FACTOR_W-1:0]  factor;
    logic [DIVISOR_W-1:0] divisor;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [HIT_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [HIT_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_UPDATE,
    ST_DIVIDE
  } state_t;

endpackage

`default_nettype wire

### sv/nshf_cfg_regs.sv
`default_nettype none

module nshf_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [nshf_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [nshf_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [nshf_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output nshf_pkg::cfg_t                        cfg_o
);

  nshf_pkg::cfg_t cfg_r;
  nshf_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign wr_en   = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx = cfg_paddr[3:2];
  assign cfg_o   = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        nshf_pkg::REG_SIGMA:   cfg_nxt.sigma   = cfg_pwdata[nshf_pkg::SIGMA_W-1:0];
        nshf_pkg::REG_FACTOR:  cfg_nxt.factor  = cfg_pwdata[nshf_pkg::FACTOR_W-1:0];
        nshf_pkg::REG_DIVISOR: cfg_nxt.divisor = cfg_pwdata[nshf_pkg::DIVISOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      nshf_pkg::REG_SIGMA:   cfg_prdata = {16'd0, cfg_r.sigma};
      nshf_pkg::REG_FACTOR:  cfg_prdata = {24'd0, cfg_r.factor};
      nshf_pkg::REG_DIVISOR: cfg_prdata = {16'd0, cfg_r.divisor};
      default:               cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sigma   <= nshf_pkg::SIGMA_RST;
      cfg_r.factor  <= nshf_pkg::FACTOR_RST;
      cfg_r.divisor <= nshf_pkg::DIVISOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/nshf_divider.sv
`default_nettype none

// restoring divider, one quotient bit per cycle, signed dividend truncated toward zero
module nshf_divider (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  nshf_pkg::div_req_t      req_i,
  output nshf_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned QW = nshf_pkg::HIT_W;
  localparam int unsigned DW = nshf_pkg::DIVISOR_W;

  logic                 busy_r,  busy_nxt;
  logic                 done_r,  done_nxt;
  logic [4:0]           cnt_r,   cnt_nxt;
  logic                 neg_r,   neg_nxt;
  logic [DW-1:0]        dvs_r,   dvs_nxt;
  logic [DW-1:0]        rem_r,   rem_nxt;
  logic [QW-1:0]        quo_r,   quo_nxt;
  logic [DW:0]          trial;
  logic [DW:0]          diff;

  assign trial = {rem_r, quo_r[QW-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req_i.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      neg_nxt  = req_i.dividend[QW-1];
      dvs_nxt  = (req_i.divisor == '0) ? DW'(1) : req_i.divisor;
      rem_nxt  = '0;
      quo_nxt  = req_i.dividend[QW-1] ? (QW'(0) - req_i.dividend) : req_i.dividend;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp_o.done     = done_r;
  assign rsp_o.quotient = neg_r ? (QW'(0) - quo_r) : quo_r;

endmodule

`default_nettype wire

### sv/noise_scaled_hit_finder.sv
`default_nettype none

// Threshold-crossing hit finder with a noise-scaled threshold. Each input word carries one
// pedestal-subtracted sample, its noise spread and its channel; a sample counts as over
// threshold when sample*256 > sigma_threshold*spread (sigma_threshold is unsigned Q8.8).
// A run of samples over threshold forms one hit: start tick = sample index * downsample
// factor, charge = first sample plus sample*factor for each later one, duration = factor
// per sample. The first sample under threshold closes the hit and one result word carries
// channel, start, charge / charge_divisor (truncated toward zero) and duration. The word
// flagged with in_tlast is not tested: it clears the sample index and drops an open hit.
// Accumulators saturate at 32 bits, the sample index at 2^COUNT_WIDTH-1.
// A word that closes no hit passes the accept, multiply and update states before the
// next word is taken; an end-of-waveform word stays in the accept state. A word that
// closes a hit also waits in a divide state for the single radix-2 divider, which
// produces one quotient bit per cycle, before the next word can be taken. A finished
// result waits in the output register, and the next input word is taken meanwhile; the
// divider hands over only once that register is free, so a stalled result word adds its
// stall to the next hit. Configuration registers: 0x0 sigma_threshold, 0x4
// downsample_factor, 0x8 charge_divisor (zero acts as one); write them only while the
// block is idle.
module noise_scaled_hit_finder #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // adc_sample[15:0], noise_spread[31:16], channel_id[51:32], zero pad [55:52]
  input  wire logic [nshf_pkg::IN_DATA_W-1:0]     in_tdata,
  // end_of_waveform
  input  wire logic                               in_tlast,
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // hit_channel[19:0], hit_start[51:20], hit_charge[83:52], hit_duration[115:84], pad
  output logic      [nshf_pkg::OUT_DATA_W-1:0]    out_tdata,
  // configuration port
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [nshf_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [nshf_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [nshf_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                    cfg_pready
);

  localparam int unsigned SW  = nshf_pkg::SAMPLE_W;
  localparam int unsigned HW  = nshf_pkg::HIT_W;
  localparam int unsigned FW  = nshf_pkg::FACTOR_W;
  localparam int unsigned CW  = nshf_pkg::CHAN_W;
  // sample index times factor, widened so the saturation check always has upper bits
  localparam int unsigned PW  = COUNT_WIDTH + FW;
  localparam int unsigned PXW = (PW > HW + 1) ? PW : HW + 1;
  localparam int unsigned TW  = nshf_pkg::SIGMA_W + SW + 1;   // threshold product
  localparam int unsigned MW  = SW + FW + 1;                  // sample * factor

  nshf_pkg::cfg_t     cfg;
  nshf_pkg::div_req_t div_req;
  nshf_pkg::div_rsp_t div_rsp;

  nshf_pkg::state_t state_r, state_nxt;

  // captured input word
  logic signed [SW-1:0] adc_r,    adc_nxt;
  logic signed [SW-1:0] spread_r, spread_nxt;
  logic [CW-1:0]        chan_r,   chan_nxt;

  // products from the multiply cycle
  logic signed [TW-1:0] thr_r,  thr_nxt;
  logic signed [MW-1:0] mul_r,  mul_nxt;
  logic [PW-1:0]        idxp_r, idxp_nxt;

  // hit tracking state
  logic                   in_hit_r, in_hit_nxt;
  logic [COUNT_WIDTH-1:0] index_r,  index_nxt;
  logic [HW-1:0]          start_r,  start_nxt;
  logic signed [HW-1:0]   charge_r, charge_nxt;
  logic [HW-1:0]          ticks_r,  ticks_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [nshf_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic signed [TW-1:0]   lhs;
  logic                   over;
  logic signed [HW+1:0]   charge_sum;
  logic [HW:0]            ticks_sum;
  logic [PXW-1:0]         idxp_x;

  nshf_cfg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_o       (cfg)
  );

  nshf_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign cfg_pready = 1'b1;
  assign in_tready  = (state_r == nshf_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // sample*256 against the threshold product, both signed
  assign lhs  = TW'($signed({adc_r, 8'd0}));
  assign over = lhs > thr_r;

  assign charge_sum = (HW+2)'(charge_r) + (HW+2)'(mul_r);
  assign ticks_sum  = {1'b0, ticks_r} + (HW+1)'(cfg.factor);
  assign idxp_x     = PXW'(idxp_r);

  always_comb begin
    state_nxt     = state_r;
    adc_nxt       = adc_r;
    spread_nxt    = spread_r;
    chan_nxt      = chan_r;
    thr_nxt       = thr_r;
    mul_nxt       = mul_r;
    idxp_nxt      = idxp_r;
    in_hit_nxt    = in_hit_r;
    index_nxt     = index_r;
    start_nxt     = start_r;
    charge_nxt    = charge_r;
    ticks_nxt     = ticks_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_req.start    = 1'b0;
    div_req.dividend = charge_r;
    div_req.divisor  = cfg.divisor;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      nshf_pkg::ST_IDLE: begin
        if (in_acc) begin
          adc_nxt    = in_tdata[15:0];
          spread_nxt = in_tdata[31:16];
          chan_nxt   = in_tdata[51:32];
          if (in_tlast) begin
            // end of waveform: no test, state back to reset values
            in_hit_nxt = 1'b0;
            index_nxt  = '0;
            start_nxt  = '0;
            charge_nxt = '0;
            ticks_nxt  = '0;
          end else begin
            state_nxt = nshf_pkg::ST_EVAL;
          end
        end
      end

      nshf_pkg::ST_EVAL: begin
        thr_nxt   = $signed({1'b0, cfg.sigma}) * spread_r;
        mul_nxt   = adc_r * $signed({1'b0, cfg.factor});
        idxp_nxt  = index_r * cfg.factor;
        state_nxt = nshf_pkg::ST_UPDATE;
      end

      nshf_pkg::ST_UPDATE: begin
        state_nxt = nshf_pkg::ST_IDLE;
        if (over && !in_hit_r) begin
          // rising crossing opens a hit
          start_nxt  = (|idxp_x[PXW-1:HW]) ? '1 : idxp_x[HW-1:0];
          charge_nxt = HW'(adc_r);
          ticks_nxt  = HW'(cfg.factor);
        end else if (over && in_hit_r) begin
          if (charge_sum[HW+1:HW-1] != 3'b000 && charge_sum[HW+1:HW-1] != 3'b111) begin
            charge_nxt = charge_sum[HW+1] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}};
          end else begin
            charge_nxt = charge_sum[HW-1:0];
          end
          ticks_nxt = ticks_sum[HW] ? '1 : ticks_sum[HW-1:0];
        end else if (!over && in_hit_r) begin
          // falling crossing closes the hit, charge goes through the divider
          div_req.start = 1'b1;
          state_nxt     = nshf_pkg::ST_DIVIDE;
        end
        in_hit_nxt = over;
        if (!(&index_r)) begin
          index_nxt = index_r + COUNT_WIDTH'(1);
        end
      end

      nshf_pkg::ST_DIVIDE: begin
        if (div_rsp.done && out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'd0, ticks_r, div_rsp.quotient, start_r, chan_r};
          state_nxt     = nshf_pkg::ST_IDLE;
        end
      end

      default: state_nxt = nshf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nshf_pkg::ST_IDLE;
      in_hit_r    <= 1'b0;
      index_r     <= '0;
      start_r     <= '0;
      charge_r    <= '0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_hit_r    <= in_hit_nxt;
      index_r     <= index_nxt;
      start_r     <= start_nxt;
      charge_r    <= charge_nxt;
      ticks_r     <= ticks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    adc_r      <= adc_nxt;
    spread_r   <= spread_nxt;
    chan_r     <= chan_nxt;
    thr_r      <= thr_nxt;
    mul_r      <= mul_nxt;
    idxp_r     <= idxp_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

### sim/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_W = 32;
  // far beyond the slowest legal run: every word closing a hit behind the longest stalls
  localparam int unsigned WATCHDOG_NS = 15_000_000;

  // one input word as the block sees it
  typedef struct {
    logic signed [nshf_pkg::SAMPLE_W-1:0] adc;
    logic signed [nshf_pkg::SAMPLE_W-1:0] spread;
    logic        [nshf_pkg::CHAN_W-1:0]   chan;
    logic                                 eow;
  } sample_t;

  // one hit word
  typedef struct {
    logic [nshf_pkg::CHAN_W-1:0] chan;
    logic [nshf_pkg::HIT_W-1:0]  start;
    logic [nshf_pkg::HIT_W-1:0]  charge;
    logic [nshf_pkg::HIT_W-1:0]  dur;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  // adc_sample[15:0], noise_spread[31:16], channel_id[51:32], zero pad [55:52]
  logic [nshf_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  // end_of_waveform
  logic                            in_tlast = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // hit_channel[19:0], hit_start[51:20], hit_charge[83:52], hit_duration[115:84], pad
  logic [nshf_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [nshf_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [nshf_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [nshf_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  noise_scaled_hit_finder #(
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // stimulus words not yet offered, and hits predicted but not yet seen
  sample_t samples_waiting[$];
  hit_t    hits_due[$];
  int      samples_queued = 0;
  int      samples_taken = 0;
  int      mismatches = 0;
  // no idling on either side while set
  bit      calm = 1'b0;
  // word currently offered on the input side
  sample_t in_word;

  // our copy of the registers
  logic [nshf_pkg::SIGMA_W-1:0]   thr_q8 = nshf_pkg::SIGMA_RST;
  logic [nshf_pkg::FACTOR_W-1:0]  tick_factor = nshf_pkg::FACTOR_RST;
  logic [nshf_pkg::DIVISOR_W-1:0] q_divisor = nshf_pkg::DIVISOR_RST;

  // our copy of the pulse tracking state
  bit     pulse_open = 1'b0;
  longint sample_count = 0;
  longint pulse_start = 0;
  longint pulse_charge = 0;
  longint pulse_ticks = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint sat_u32(longint v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // advance the pulse tracker by one accepted word, queueing a hit when one closes
  function automatic void track_hit(sample_t s);
    longint adc;
    longint spread;
    longint quot;
    longint div;
    bit     over;
    hit_t   h;
    adc = s.adc;
    spread = s.spread;
    // end of waveform: no threshold test, everything back to zero
    if (s.eow) begin
      pulse_open = 1'b0;
      sample_count = 0;
      pulse_start = 0;
      pulse_charge = 0;
      pulse_ticks = 0;
      return;
    end
    over = (adc * 256) > (longint'(thr_q8) * spread);
    if (over && !pulse_open) begin
      // rising crossing opens a pulse
      pulse_start = sat_u32(sample_count * longint'(tick_factor));
      pulse_charge = adc;
      pulse_ticks = tick_factor;
    end else if (over) begin
      pulse_charge = sat_s32(pulse_charge + adc * longint'(tick_factor));
      pulse_ticks = sat_u32(pulse_ticks + longint'(tick_factor));
    end else if (pulse_open) begin
      // falling crossing closes it; a zero divisor acts as one, division truncates to zero
      div = (q_divisor == '0) ? 1 : longint'(q_divisor);
      quot = pulse_charge / div;
      h.chan = s.chan;
      h.start = pulse_start[nshf_pkg::HIT_W-1:0];
      h.charge = quot[nshf_pkg::HIT_W-1:0];
      h.dur = pulse_ticks[nshf_pkg::HIT_W-1:0];
      hits_due.insert(hits_due.size(), h);
    end
    pulse_open = over;
    if (sample_count < ((longint'(1) << COUNT_W) - 1)) sample_count++;
  endfunction

  function automatic int pick_in(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return pick_in(1, 3);
    if (r < 97) return pick_in(4, 12);
    return pick_in(20, 60);
  endfunction

  task automatic check_field(string name, logic [nshf_pkg::HIT_W-1:0] want,
                             logic [nshf_pkg::HIT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // input driver: offers queued words, random gaps between them
  always @(posedge clk) begin : drive_in
    sample_t nxt;
    int      idle_left;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_hit(in_word);
        samples_taken++;
      end
      // slot is free when nothing is offered or the offered word just went in
      if (!in_tvalid || in_tready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_tvalid <= 1'b0;
        end else if (samples_waiting.size() > 0) begin
          nxt = samples_waiting.pop_front();
          in_word <= nxt;
          in_tdata <= nshf_pkg::IN_DATA_W'({nxt.chan, nxt.spread, nxt.adc});
          in_tlast <= nxt.eow;
          in_tvalid <= 1'b1;
          idle_left = calm ? 0 : pick_idle();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin : watch_out
    hit_t got;
    hit_t want;
    int   stall_left;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.chan = out_tdata[nshf_pkg::CHAN_W-1:0];
        got.start = out_tdata[nshf_pkg::CHAN_W +: nshf_pkg::HIT_W];
        got.charge = out_tdata[nshf_pkg::CHAN_W+nshf_pkg::HIT_W +: nshf_pkg::HIT_W];
        got.dur = out_tdata[nshf_pkg::CHAN_W+2*nshf_pkg::HIT_W +: nshf_pkg::HIT_W];
        if (hits_due.size() == 0) begin
          $error("hit word with no hit pending: channel %0h start %0h", got.chan, got.start);
          mismatches++;
        end else begin
          want = hits_due.pop_front();
          check_field("hit_channel", nshf_pkg::HIT_W'(want.chan), nshf_pkg::HIT_W'(got.chan));
          check_field("hit_start", want.start, got.start);
          check_field("hit_charge", want.charge, got.charge);
          check_field("hit_duration", want.dur, got.dur);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm) stall_left = pick_idle();
      end
    end
  end

  task automatic feed(int adc, int spread, int chan, bit eow);
    sample_t s;
    s.adc = adc[nshf_pkg::SAMPLE_W-1:0];
    s.spread = spread[nshf_pkg::SAMPLE_W-1:0];
    s.chan = chan[nshf_pkg::CHAN_W-1:0];
    s.eow = eow;
    samples_waiting.insert(samples_waiting.size(), s);
    samples_queued++;
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(nshf_pkg::reg_index_t idx, logic [nshf_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      nshf_pkg::REG_SIGMA:   thr_q8 = val[nshf_pkg::SIGMA_W-1:0];
      nshf_pkg::REG_FACTOR:  tick_factor = val[nshf_pkg::FACTOR_W-1:0];
      nshf_pkg::REG_DIVISOR: q_divisor = val[nshf_pkg::DIVISOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int sigma, int factor, int divisor);
    write_reg(nshf_pkg::REG_SIGMA, nshf_pkg::CFG_DATA_W'(sigma));
    write_reg(nshf_pkg::REG_FACTOR, nshf_pkg::CFG_DATA_W'(factor));
    write_reg(nshf_pkg::REG_DIVISOR, nshf_pkg::CFG_DATA_W'(divisor));
  endtask

  // wait for every word to go in and every hit to come out, then let the block go quiet
  task automatic settle();
    int waited;
    waited = 0;
    while (samples_taken != samples_queued) @(posedge clk);
    while (hits_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (hits_due.size() != 0) begin
      $error("%0d hit words never arrived", hits_due.size());
      mismatches++;
      hits_due.delete();
    end
    // a word without a result may still be in flight
    repeat (40) @(posedge clk);
  endtask

  // a plausible waveform: alternating runs under and over the current threshold,
  // closed by an end-of-waveform word
  task automatic feed_waveform();
    int     chan;
    int     len;
    int     run;
    int     smax;
    int     spread;
    int     adc;
    longint thr;
    bit     high;
    chan = $urandom_range(20'hFFFFF);
    len = ($urandom_range(9) == 0) ? pick_in(40, 90) : pick_in(3, 30);
    high = $urandom_range(1);
    run = pick_in(1, 5);
    // keep the threshold inside the sample range
    smax = (thr_q8 == '0) ? 32767 : ((8_192_000 / int'(thr_q8)) > 32767 ? 32767
                                     : 8_192_000 / int'(thr_q8));
    for (int i = 0; i < len; i++) begin
      if (run == 0) begin
        high = !high;
        run = pick_in(1, 6);
      end
      spread = pick_in(-(smax / 8), smax);
      thr = (longint'(thr_q8) * spread) >>> 8;
      // values right at the boundary now and then
      if (high) begin
        adc = ($urandom_range(4) == 0) ? int'(thr) + 1
              : pick_in(int'(thr) + 1, (thr + 3000 > 32767) ? 32767 : int'(thr) + 3000);
      end else begin
        adc = ($urandom_range(4) == 0) ? int'(thr)
              : pick_in((thr - 3000 < -32768) ? -32768 : int'(thr) - 3000, int'(thr));
      end
      feed(adc, spread, ($urandom_range(9) == 0) ? int'($urandom_range(20'hFFFFF)) : chan, 1'b0);
      run--;
    end
    feed(int'($urandom_range(16'hFFFF)), int'($urandom_range(16'hFFFF)), chan, 1'b1);
  endtask

  // mostly waveforms, some fully random words
  task automatic feed_random(int count);
    int start;
    start = samples_queued;
    while (samples_queued - start < count) begin
      if ($urandom_range(9) == 0)
        feed(int'($urandom_range(16'hFFFF)), int'($urandom_range(16'hFFFF)),
             int'($urandom_range(20'hFFFFF)), $urandom_range(3) == 0);
      else
        feed_waveform();
    end
  endtask

  task automatic feed_run(int adc, int spread, int chan, int count);
    for (int i = 0; i < count; i++) feed(adc, spread, chan, 1'b0);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed words under the reset settings (threshold 5.0, factor 1, divisor 1)
    feed(32767, 0, 0, 1'b0);              // most positive sample opens a hit
    feed(-32768, -32768, 20'hFFFFF, 1'b0); // most negative sample still over
    feed(0, 0, 20'hFFFFF, 1'b0);          // zero against zero is not over: closes
    feed(-32768, 32767, 0, 1'b0);
    feed(1280, 256, 5, 1'b0);             // exactly on the threshold: not over
    feed(1281, 256, 5, 1'b0);             // one above it opens
    feed(1280, 256, 5, 1'b0);
    feed(1281, 256, 7, 1'b0);
    feed(32767, -32768, 7, 1'b1);         // end of waveform drops the open hit
    feed(0, 0, 7, 1'b0);
    feed(-1, -1, 20'hFFFFF, 1'b0);        // negative sample over a negative threshold
    feed(-32768, 32767, 20'h5A5A5, 1'b0);
    feed(0, 0, 0, 1'b1);
    settle();

    // downsample factor zero and charge divisor zero
    set_regs(1280, 0, 0);
    feed(1281, 256, 3, 1'b0);
    feed(32767, 256, 3, 1'b0);            // adds no charge, no ticks
    feed(1280, 256, 3, 1'b0);
    feed(0, 0, 3, 1'b1);
    feed_random(130);
    settle();

    // long positive pulse drives the charge into positive saturation
    set_regs(0, 255, 1);
    feed_run(32767, 0, 20'h12345, 270);
    feed(0, 0, 20'h12345, 1'b0);
    feed(0, 0, 20'h12345, 1'b1);
    feed_random(130);
    settle();

    // and negative saturation, with no idling on either side
    calm = 1'b1;
    set_regs(65535, 255, 1);
    feed_run(-32768, -32768, 20'hABCDE, 270);
    feed(0, 0, 20'hABCDE, 1'b0);
    feed(0, 0, 20'hABCDE, 1'b1);
    feed_random(130);
    settle();
    calm = 1'b0;

    set_regs(0, 255, 65535);
    feed_random(130);
    settle();

    set_regs(65535, 1, 3);
    feed_random(130);
    settle();

    set_regs(256, 4, 7);
    feed_random(130);
    settle();

    set_regs(int'($urandom_range(65535)), pick_in(1, 255), pick_in(1, 65535));
    feed_random(130);
    settle();

    calm = 1'b1;
    set_regs(int'($urandom_range(65535)), pick_in(1, 255), pick_in(1, 65535));
    feed_random(130);
    settle();

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("testbench failed");
    $finish;
  end

endmodule

`default_nettype wire
